// File: rtl/sas_pkg.sv
// Shared types, constants and helpers for the three-axis stepper sequencer.
// No dependencies; imported by the channel interfaces and the top level.
package sas_pkg;

  localparam int unsigned AXIS_COUNT_DEF = 3;
  localparam int unsigned PHASE_COUNT    = 4;
  localparam int unsigned POSITION_BITS  = 10;
  localparam int unsigned PHASE_BITS     = $clog2(PHASE_COUNT);
  localparam int unsigned AXIS_BITS      = 2;
  localparam int unsigned FUNC_BITS      = 2;
  localparam int unsigned MASK_BITS      = 3;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned CFG_ADDR_W     = 5;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [PHASE_BITS-1:0]    PHASE_LAST = PHASE_BITS'(PHASE_COUNT - 1);

  // reset values of the configuration registers
  localparam logic [POSITION_BITS-1:0] MAX_X_RST = POSITION_BITS'(202);
  localparam logic [POSITION_BITS-1:0] MAX_Y_RST = POSITION_BITS'(600);
  localparam logic [POSITION_BITS-1:0] MAX_Z_RST = POSITION_BITS'(600);
  localparam logic [MASK_BITS-1:0]     INVERT_RST = 3'd4;
  localparam logic [MASK_BITS-1:0]     UPPER_RST  = 3'd1;
  localparam logic [MASK_BITS-1:0]     DEVICE_RST = 3'd4;

  // register word indexes (byte address / 4)
  localparam logic [2:0] REG_MAX_X  = 3'd0;
  localparam logic [2:0] REG_MAX_Y  = 3'd1;
  localparam logic [2:0] REG_MAX_Z  = 3'd2;
  localparam logic [2:0] REG_INVERT = 3'd3;
  localparam logic [2:0] REG_UPPER  = 3'd4;
  localparam logic [2:0] REG_DEVICE = 3'd5;

  // command codes
  localparam logic [FUNC_BITS-1:0] FUNC_MOVE = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_HOME = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_TICK = 2'd2;

  localparam logic [BYTE_BITS-1:0] KEEP_LOW  = 8'h0f;
  localparam logic [BYTE_BITS-1:0] KEEP_HIGH = 8'hf0;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_MOVE    = 3'd1,
    MODE_SEEK    = 3'd2,
    MODE_BACKOFF = 3'd3,
    MODE_FINISH  = 3'd4
  } run_mode_t;

  // full-step coil pattern
  function automatic logic [BYTE_BITS-1:0] phase_pattern(input logic [PHASE_BITS-1:0] idx);
    logic [BYTE_BITS-1:0] pat;
    case (idx)
      2'd0:    pat = 8'h09;
      2'd1:    pat = 8'h05;
      2'd2:    pat = 8'h06;
      2'd3:    pat = 8'h0a;
      default: pat = 8'h09;
    endcase
    return pat;
  endfunction

  // per-axis mask bit; axis 3 has no bit and reads 0
  function automatic logic mask_bit(input logic [MASK_BITS-1:0] mask,
                                    input logic [AXIS_BITS-1:0] ax);
    logic b;
    case (ax)
      2'd0:    b = mask[0];
      2'd1:    b = mask[1];
      2'd2:    b = mask[2];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

  // bits of the port byte that survive a clear of the motor nibble
  function automatic logic [BYTE_BITS-1:0] keep_mask(input logic upper);
    return upper ? KEEP_LOW : KEEP_HIGH;
  endfunction

endpackage

// File: rtl/sas_if.sv
// Valid/ready channel interfaces for the stepper sequencer: command beats in,
// result beats out. Depends on sas_pkg for field widths.
interface sas_in_if import sas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_BITS-1:0]     func;
  logic [AXIS_BITS-1:0]     axis;
  logic [POSITION_BITS-1:0] target;
  logic [MASK_BITS-1:0]     limit_bits;
  logic [BYTE_BITS-1:0]     existing_byte;

  modport source (output valid, func, axis, target, limit_bits, existing_byte,
                  input ready);
  modport sink   (input valid, func, axis, target, limit_bits, existing_byte,
                  output ready);
endinterface

interface sas_out_if import sas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     write_valid;
  logic                     device_select;
  logic [BYTE_BITS-1:0]     port_byte;
  logic                     busy_res;
  logic                     done_res;
  logic [POSITION_BITS-1:0] position;

  modport source (output valid, write_valid, device_select, port_byte, busy_res,
                  done_res, position, input ready);
  modport sink   (input valid, write_valid, device_select, port_byte, busy_res,
                  done_res, position, output ready);
endinterface

// File: rtl/stepper_axis_sequencer_unit.sv
// Stepper sequencer top level: up to four axes sharing expander port bytes.
// Pipeline: an accepted beat lands in the input stage, then moves on to the result
//   register when that drains (two register stages: input stage, result register).
// Throughput: one beat per cycle while results are taken; a full input stage stalls
//   while a result waits, and all run state updates in the stage-to-result cycle.
// Reset (rst_n low, synchronous): run idle, positions 0, registers to defaults.
module stepper_axis_sequencer_unit import sas_pkg::*; #(
  parameter int unsigned AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sas_in_if.sink                in_if,
  sas_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero wait states)
  // ---------------------------------------------------------------------------
  logic [POSITION_BITS-1:0] max_x_r, max_y_r, max_z_r;
  logic [MASK_BITS-1:0]     invert_r, upper_r, device_r;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r  <= MAX_X_RST;
      max_y_r  <= MAX_Y_RST;
      max_z_r  <= MAX_Z_RST;
      invert_r <= INVERT_RST;
      upper_r  <= UPPER_RST;
      device_r <= DEVICE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_X:  max_x_r  <= pwdata[POSITION_BITS-1:0];
        REG_MAX_Y:  max_y_r  <= pwdata[POSITION_BITS-1:0];
        REG_MAX_Z:  max_z_r  <= pwdata[POSITION_BITS-1:0];
        REG_INVERT: invert_r <= pwdata[MASK_BITS-1:0];
        REG_UPPER:  upper_r  <= pwdata[MASK_BITS-1:0];
        REG_DEVICE: device_r <= pwdata[MASK_BITS-1:0];
        default: ;  // writes past the map are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_X:  prdata = CFG_DATA_W'(max_x_r);
      REG_MAX_Y:  prdata = CFG_DATA_W'(max_y_r);
      REG_MAX_Z:  prdata = CFG_DATA_W'(max_z_r);
      REG_INVERT: prdata = CFG_DATA_W'(invert_r);
      REG_UPPER:  prdata = CFG_DATA_W'(upper_r);
      REG_DEVICE: prdata = CFG_DATA_W'(device_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input stage -> result register
  // The stage drains whenever the result register is empty or being taken.
  // ---------------------------------------------------------------------------
  logic stage_valid_r;
  logic out_valid_r;
  logic advance;

  logic [FUNC_BITS-1:0]     s_func_r;
  logic [AXIS_BITS-1:0]     s_axis_r;
  logic [POSITION_BITS-1:0] s_target_r;
  logic [MASK_BITS-1:0]     s_limit_r;
  logic [BYTE_BITS-1:0]     s_byte_r;

  assign advance     = stage_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      stage_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s_func_r   <= in_if.func;
      s_axis_r   <= in_if.axis;
      s_target_r <= in_if.target;
      s_limit_r  <= in_if.limit_bits;
      s_byte_r   <= in_if.existing_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Run state
  // ---------------------------------------------------------------------------
  run_mode_t                mode_r, mode_nxt;
  logic [PHASE_BITS-1:0]    phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] steps_r, steps_nxt;
  logic                     dir_r, dir_nxt;       // 1 = position rising
  logic [AXIS_BITS-1:0]     active_r, active_nxt;
  logic [BYTE_BITS-1:0]     saved_r, saved_nxt;
  logic [POSITION_BITS-1:0] pos_r [AXIS_COUNT];

  // lane reads: commanded axis and active axis
  logic [POSITION_BITS-1:0] cmd_pos, act_pos;
  always_comb begin
    cmd_pos = '0;
    act_pos = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (s_axis_r == AXIS_BITS'(i)) cmd_pos = pos_r[i];
      if (active_r == AXIS_BITS'(i)) act_pos = pos_r[i];
    end
  end

  logic [POSITION_BITS-1:0] cmd_max;
  always_comb begin
    case (s_axis_r)
      2'd0:    cmd_max = max_x_r;
      2'd1:    cmd_max = max_y_r;
      2'd2:    cmd_max = max_z_r;
      default: cmd_max = POS_MAX;
    endcase
  end

  // command decode
  logic                     is_cmd, cmd_ok, go_home, up;
  logic [POSITION_BITS-1:0] tgt_clamp, diff;

  assign is_cmd    = (s_func_r == FUNC_MOVE) || (s_func_r == FUNC_HOME);
  assign cmd_ok    = is_cmd && (mode_r == MODE_IDLE) &&
                     ({1'b0, s_axis_r} < 3'(AXIS_COUNT));
  assign go_home   = (s_func_r == FUNC_HOME) || (s_target_r == '0);
  assign tgt_clamp = (s_target_r > cmd_max) ? cmd_max : s_target_r;
  assign up        = tgt_clamp > cmd_pos;
  assign diff      = up ? (tgt_clamp - cmd_pos) : (cmd_pos - tgt_clamp);

  // tick decode
  logic                     is_tick, pressed, ph0, seek_hit, home_done, stepping;
  logic                     wrap, dir_eff, motor_fwd, upper_act;
  logic [POSITION_BITS-1:0] steps_dec, step_pos;
  logic [PHASE_BITS-1:0]    pat_idx;
  logic [BYTE_BITS-1:0]     cleared, phase_byte;

  assign is_tick   = (s_func_r == FUNC_TICK) && (mode_r != MODE_IDLE);
  assign pressed   = mask_bit(s_limit_r, active_r);
  assign ph0       = (phase_r == '0);
  // seek turns into back-off on the step boundary where the switch reads pressed
  assign seek_hit  = (mode_r == MODE_SEEK) && ph0 && pressed;
  assign home_done = (mode_r == MODE_BACKOFF) && ph0 && !pressed;
  assign stepping  = is_tick && (mode_r != MODE_FINISH) && !home_done;
  assign wrap      = (phase_r == PHASE_LAST);
  assign dir_eff   = seek_hit ? 1'b1 : dir_r;
  assign steps_dec = steps_r - 1'b1;

  // positions saturate at both ends
  always_comb begin
    if (dir_eff) step_pos = (act_pos == POS_MAX) ? act_pos : act_pos + 1'b1;
    else         step_pos = (act_pos == '0) ? act_pos : act_pos - 1'b1;
  end

  assign upper_act  = mask_bit(upper_r, active_r);
  assign cleared    = saved_r & keep_mask(upper_act);
  assign motor_fwd  = dir_eff ^ mask_bit(invert_r, active_r);
  assign pat_idx    = motor_fwd ? phase_r : (PHASE_LAST - phase_r);
  assign phase_byte = (upper_act ? (phase_pattern(pat_idx) << 4) : phase_pattern(pat_idx))
                      | cleared;

  // next run mode
  always_comb begin
    mode_nxt = mode_r;
    if (cmd_ok) begin
      if (go_home)          mode_nxt = MODE_SEEK;
      else if (diff == '0)  mode_nxt = MODE_FINISH;
      else                  mode_nxt = MODE_MOVE;
    end else if (is_tick) begin
      case (mode_r)
        MODE_FINISH:  mode_nxt = MODE_IDLE;
        MODE_SEEK:    mode_nxt = seek_hit ? MODE_BACKOFF : MODE_SEEK;
        MODE_BACKOFF: mode_nxt = home_done ? MODE_IDLE : MODE_BACKOFF;
        MODE_MOVE:    mode_nxt = (wrap && steps_dec == '0) ? MODE_FINISH : MODE_MOVE;
        default:      mode_nxt = mode_r;
      endcase
    end
  end

  // datapath next values and result fields
  logic                     pos_we;
  logic [POSITION_BITS-1:0] pos_wdata;
  logic                     res_wv, res_dev, res_done;
  logic [BYTE_BITS-1:0]     res_byte;
  logic [POSITION_BITS-1:0] res_pos;

  always_comb begin
    phase_nxt  = phase_r;
    steps_nxt  = steps_r;
    dir_nxt    = dir_r;
    active_nxt = active_r;
    saved_nxt  = saved_r;
    pos_we     = 1'b0;
    pos_wdata  = step_pos;
    res_wv     = 1'b0;
    res_byte   = '0;
    res_done   = 1'b0;
    res_pos    = act_pos;
    if (cmd_ok) begin
      active_nxt = s_axis_r;
      saved_nxt  = s_byte_r;
      phase_nxt  = '0;
      dir_nxt    = go_home ? 1'b0 : up;
      steps_nxt  = go_home ? '0 : diff;
      res_wv     = 1'b1;
      res_byte   = s_byte_r & keep_mask(mask_bit(upper_r, s_axis_r));
      res_pos    = cmd_pos;
    end else if (is_tick) begin
      res_wv = 1'b1;
      if (!stepping) begin
        // finishing tick: cleared byte, done; homing also zeroes the axis
        res_byte = cleared;
        res_done = 1'b1;
        if (home_done) begin
          pos_we    = 1'b1;
          pos_wdata = '0;
          res_pos   = '0;
        end
      end else begin
        res_byte  = phase_byte;
        dir_nxt   = dir_eff;
        phase_nxt = phase_r + 1'b1;
        if (wrap) begin
          pos_we  = 1'b1;
          res_pos = step_pos;
          if (mode_r == MODE_MOVE) steps_nxt = steps_dec;
        end
      end
    end
    res_dev = mask_bit(device_r, active_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      phase_r  <= '0;
      steps_r  <= '0;
      dir_r    <= 1'b0;
      active_r <= '0;
      saved_r  <= '0;
      for (int i = 0; i < AXIS_COUNT; i++) pos_r[i] <= '0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      steps_r  <= steps_nxt;
      dir_r    <= dir_nxt;
      active_r <= active_nxt;
      saved_r  <= saved_nxt;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        if (pos_we && active_r == AXIS_BITS'(i)) pos_r[i] <= pos_wdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                     out_wv_r, out_dev_r, out_busy_r, out_done_r;
  logic [BYTE_BITS-1:0]     out_byte_r;
  logic [POSITION_BITS-1:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_wv_r   <= res_wv;
      out_dev_r  <= res_dev;
      out_byte_r <= res_byte;
      out_busy_r <= (mode_nxt != MODE_IDLE);
      out_done_r <= res_done;
      out_pos_r  <= res_pos;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.write_valid   = out_wv_r;
  assign out_if.device_select = out_dev_r;
  assign out_if.port_byte     = out_byte_r;
  assign out_if.busy_res      = out_busy_r;
  assign out_if.done_res      = out_done_r;
  assign out_if.position      = out_pos_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_busy_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_busy_r == (mode_r != MODE_IDLE)))
    else $error("busy flag disagrees with run mode");

  a_move_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_MOVE) |-> (steps_r != '0))
    else $error("move run with no steps left");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_busy_r)
    else $error("done reported while still busy");

  a_phase_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != '0) |-> (mode_r == MODE_MOVE || mode_r == MODE_SEEK ||
                         mode_r == MODE_BACKOFF))
    else $error("phase off a step boundary outside an active run");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !advance) |=> (stage_valid_r && $stable(s_func_r)))
    else $error("stalled input stage lost its beat");

endmodule

// File: tb/stepper_axis_sequencer_unit_test.sv
// Self-checking bench for the three-axis stepper sequencer: random and directed
// command/tick beats, scoreboard prediction of every result beat, APB register setup.
// Depends on sas_pkg, sas_if (sas_in_if, sas_out_if) and stepper_axis_sequencer_unit.
import sas_pkg::*;

typedef struct {
  logic [FUNC_BITS-1:0]     func;
  logic [AXIS_BITS-1:0]     axis;
  logic [POSITION_BITS-1:0] target;
  logic [MASK_BITS-1:0]     limit_bits;
  logic [BYTE_BITS-1:0]     existing_byte;
} cmd_t;

typedef struct {
  logic                     write_valid;
  logic                     device_select;
  logic [BYTE_BITS-1:0]     port_byte;
  logic                     busy_res;
  logic                     done_res;
  logic [POSITION_BITS-1:0] position;
} beat_t;

// coil patterns 9,5,6,A packed low phase first
localparam logic [31:0] COIL_SEQ = 32'h0a06_0509;

class step_scoreboard;
  logic [POSITION_BITS-1:0] max_x, max_y, max_z;
  logic [MASK_BITS-1:0]     inv_m, upper_m, dev_m;
  logic [POSITION_BITS-1:0] pos [4];
  run_mode_t                mode;
  logic [PHASE_BITS-1:0]    phase;
  logic [POSITION_BITS-1:0] steps_left;
  logic                     dir;
  logic [AXIS_BITS-1:0]     act;
  logic [BYTE_BITS-1:0]     saved;
  beat_t                    pending_beats [$];
  int                       errors, n_cmds, n_homes, n_runs, n_beats;

  function new();
    max_x = MAX_X_RST; max_y = MAX_Y_RST; max_z = MAX_Z_RST;
    inv_m = INVERT_RST; upper_m = UPPER_RST; dev_m = DEVICE_RST;
    foreach (pos[i]) pos[i] = '0;
    mode = MODE_IDLE; phase = '0; steps_left = '0; dir = 1'b0;
    act = '0; saved = '0;
    errors = 0; n_cmds = 0; n_homes = 0; n_runs = 0; n_beats = 0;
  endfunction

  function logic axis_flag(logic [MASK_BITS-1:0] m, logic [AXIS_BITS-1:0] ax);
    return (ax >= AXIS_BITS'(MASK_BITS)) ? 1'b0 : m[ax];
  endfunction

  function logic [POSITION_BITS-1:0] axis_limit(logic [AXIS_BITS-1:0] ax);
    case (ax)
      2'd0:    return max_x;
      2'd1:    return max_y;
      2'd2:    return max_z;
      default: return POS_MAX;
    endcase
  endfunction

  // saved byte with the active motor nibble cleared
  function logic [BYTE_BITS-1:0] kept_bits();
    return saved & (axis_flag(upper_m, act) ? KEEP_LOW : KEEP_HIGH);
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_MAX_X:  max_x   = v[POSITION_BITS-1:0];
      REG_MAX_Y:  max_y   = v[POSITION_BITS-1:0];
      REG_MAX_Z:  max_z   = v[POSITION_BITS-1:0];
      REG_INVERT: inv_m   = v[MASK_BITS-1:0];
      REG_UPPER:  upper_m = v[MASK_BITS-1:0];
      REG_DEVICE: dev_m   = v[MASK_BITS-1:0];
      default: ;
    endcase
  endfunction

  function void push(logic wv, logic [BYTE_BITS-1:0] pbyte, logic done);
    beat_t b;
    b.write_valid   = wv;
    b.device_select = axis_flag(dev_m, act);
    b.port_byte     = wv ? pbyte : '0;
    b.busy_res      = (mode != MODE_IDLE);
    b.done_res      = done;
    b.position      = pos[act];
    pending_beats.push_back(b);
  endfunction

  // note an accepted input beat and queue the result it must produce
  function void note_command(cmd_t c);
    logic [POSITION_BITS-1:0] mx, tgt, cur;
    logic                     pressed, fwd;
    logic [PHASE_BITS-1:0]    cidx;
    logic [BYTE_BITS-1:0]     coil, pbyte;
    if (c.func == FUNC_MOVE || c.func == FUNC_HOME) begin
      if (mode != MODE_IDLE || c.axis >= AXIS_COUNT_DEF) begin
        push(1'b0, '0, 1'b0);
        return;
      end
      n_cmds++;
      act = c.axis;
      saved = c.existing_byte;
      phase = '0;
      if (c.func == FUNC_HOME || c.target == '0) begin
        mode = MODE_SEEK;
        dir = 1'b0;
        steps_left = '0;
        n_homes++;
      end else begin
        mx  = axis_limit(c.axis);
        cur = pos[c.axis];
        tgt = (c.target > mx) ? mx : c.target;
        if (tgt > cur) begin
          dir = 1'b1;
          steps_left = tgt - cur;
        end else begin
          dir = 1'b0;
          steps_left = cur - tgt;
        end
        mode = (steps_left != '0) ? MODE_MOVE : MODE_FINISH;
      end
      push(1'b1, kept_bits(), 1'b0);
      return;
    end
    if (c.func != FUNC_TICK || mode == MODE_IDLE) begin
      push(1'b0, '0, 1'b0);
      return;
    end
    if (mode == MODE_FINISH) begin
      mode = MODE_IDLE;
      n_runs++;
      push(1'b1, kept_bits(), 1'b1);
      return;
    end
    // limit switch only matters on a step boundary
    pressed = axis_flag(c.limit_bits, act);
    if (mode == MODE_SEEK && phase == '0 && pressed) begin
      mode = MODE_BACKOFF;
      dir = 1'b1;
    end
    if (mode == MODE_BACKOFF && phase == '0 && !pressed) begin
      pos[act] = '0;
      mode = MODE_IDLE;
      n_runs++;
      push(1'b1, kept_bits(), 1'b1);
      return;
    end
    fwd   = dir ^ axis_flag(inv_m, act);
    cidx  = fwd ? phase : PHASE_LAST - phase;
    coil  = COIL_SEQ[cidx*8 +: 8];
    pbyte = (axis_flag(upper_m, act) ? {coil[3:0], 4'h0} : coil) | kept_bits();
    phase = phase + 1'b1;
    if (phase == '0) begin
      if (dir) begin
        if (pos[act] != POS_MAX) pos[act] = pos[act] + 1'b1;
      end else begin
        if (pos[act] != '0) pos[act] = pos[act] - 1'b1;
      end
      if (mode == MODE_MOVE) begin
        steps_left = steps_left - 1'b1;
        if (steps_left == '0) mode = MODE_FINISH;
      end
    end
    push(1'b1, pbyte, 1'b0);
  endfunction

  // compare one accepted result beat against the oldest prediction
  function void check_beat(beat_t got);
    beat_t exp_b;
    logic  bad;
    n_beats++;
    if (pending_beats.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] result beat %0d with nothing pending: wv=%0b dev=%0b byte=%02h",
                 $time, n_beats, got.write_valid, got.device_select, got.port_byte);
      return;
    end
    exp_b = pending_beats.pop_front();
    bad = (got.write_valid !== exp_b.write_valid) ||
          (got.device_select !== exp_b.device_select) ||
          (got.port_byte !== exp_b.port_byte) ||
          (got.busy_res !== exp_b.busy_res) ||
          (got.done_res !== exp_b.done_res) ||
          (got.position !== exp_b.position);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("[%0t] beat %0d exp wv=%0b dev=%0b byte=%02h busy=%0b done=%0b pos=%0d",
                 $time, n_beats, exp_b.write_valid, exp_b.device_select, exp_b.port_byte,
                 exp_b.busy_res, exp_b.done_res, exp_b.position);
        $display("[%0t] beat %0d got wv=%0b dev=%0b byte=%02h busy=%0b done=%0b pos=%0d",
                 $time, n_beats, got.write_valid, got.device_select, got.port_byte,
                 got.busy_res, got.done_res, got.position);
      end
    end
  endfunction
endclass

module stepper_axis_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;   // unused code, block ignores it
  localparam logic [AXIS_BITS-1:0] AXIS_NONE = 2'd3;   // no such axis in this build
  localparam int WATCHDOG_LIMIT = 4000;  // longest receiver hold is far below this
  localparam int HOLD_CYCLES    = 300;   // back-pressure stretch
  localparam int PHASE_ITEMS    = 240;   // random beats per register setting

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sas_in_if  in_if ();
  sas_out_if out_if ();

  stepper_axis_sequencer_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  step_scoreboard sb = new();

  int    idle_cycles = 0;
  int    burst_left  = 0;
  int    settings_used = 1;   // reset defaults count as the first
  int    hold_count  = 0;
  beat_t seen;

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Result side: check every accepted beat; watchdog on handshake inactivity.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.write_valid   = out_if.write_valid;
        seen.device_select = out_if.device_select;
        seen.port_byte     = out_if.port_byte;
        seen.busy_res      = out_if.busy_res;
        seen.done_res      = out_if.done_res;
        seen.position      = out_if.position;
        sb.check_beat(seen);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern chosen per span; twice it holds off for a long
  // stretch so the block fills and drops in_if.ready.
  // ---------------------------------------------------------------------------
  initial begin
    stall_style_t style;
    int           span;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_count < 2 && sb.n_beats >= (hold_count + 1) * 500) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_count++;
      end
      style = stall_style_t'($urandom_range(0, 3));
      span  = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        case (style)
          STALL_NONE:  out_if.ready <= 1'b1;
          STALL_HALF:  out_if.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:     out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  function automatic cmd_t mk(logic [FUNC_BITS-1:0] f, logic [AXIS_BITS-1:0] ax,
                              logic [POSITION_BITS-1:0] tg, logic [MASK_BITS-1:0] lim,
                              logic [BYTE_BITS-1:0] ex);
    cmd_t c;
    c.func = f; c.axis = ax; c.target = tg; c.limit_bits = lim; c.existing_byte = ex;
    return c;
  endfunction

  // Offer one beat; bursts of random length separated by random gaps.
  // The scoreboard notes the beat at the edge where it is taken.
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.func          <= c.func;
    in_if.axis          <= c.axis;
    in_if.target        <= c.target;
    in_if.limit_bits    <= c.limit_bits;
    in_if.existing_byte <= c.existing_byte;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_command(c);
  endtask

  // Next random beat, shaped by the predicted run state: mostly legal
  // commands when idle, mostly ticks when busy, with homing switches that
  // eventually press and release so every run ends.
  function automatic cmd_t next_cmd();
    cmd_t                     c;
    int                       roll, t;
    logic [POSITION_BITS-1:0] mx, cur;
    c = mk(FUNC_TICK, AXIS_BITS'($urandom_range(0, 3)), POSITION_BITS'($urandom_range(0, 1023)),
           MASK_BITS'($urandom_range(0, 7)), BYTE_BITS'($urandom_range(0, 255)));
    roll = $urandom_range(0, 99);
    if (sb.mode == MODE_IDLE) begin
      if (roll < 8) begin
        // noise: idle tick, unused code, command to the missing axis
        if (roll >= 5) begin
          c.func = FUNC_MOVE;
          c.axis = AXIS_NONE;
        end else if (roll >= 3) begin
          c.func = FUNC_NONE;
        end
        return c;
      end
      c.axis = AXIS_BITS'($urandom_range(0, 2));
      if (roll < 18) begin
        c.func = FUNC_HOME;
        return c;
      end
      c.func = FUNC_MOVE;
      mx  = sb.axis_limit(c.axis);
      cur = sb.pos[c.axis];
      if (roll < 26) begin
        c.target = '0;                  // move to zero homes
      end else if (roll < 36) begin
        c.target = cur;                 // already there
      end else if (roll < 50 && mx <= 64) begin
        c.target = POSITION_BITS'($urandom_range(int'(mx) + 1, 1023));   // clamps
      end else if (roll < 62 && mx <= 64) begin
        // keep the full-range random target
      end else begin
        t = $urandom_range(0, 1) ? int'(cur) + $urandom_range(1, 5)
                                 : int'(cur) - $urandom_range(1, 5);
        if (t < 1) t = 1;
        if (t > 1023) t = 1023;
        c.target = POSITION_BITS'(t);
      end
    end else begin
      if (roll < 4) begin
        c.func = $urandom_range(0, 1) ? FUNC_HOME : FUNC_MOVE;   // ignored while busy
        return c;
      end
      if (roll < 7) begin
        c.func = FUNC_NONE;
        return c;
      end
      if (sb.mode == MODE_SEEK)
        c.limit_bits[sb.act] = ($urandom_range(0, 5) == 0);
      else if (sb.mode == MODE_BACKOFF)
        c.limit_bits[sb.act] = ($urandom_range(0, 3) != 0);
    end
    return c;
  endfunction

  task automatic finish_run();
    while (sb.mode != MODE_IDLE) send_cmd(next_cmd());
  endtask

  // Wait until every predicted beat is back, plus pipeline slack.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup then access; upper pwdata bits carry junk the block drops.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value, input int width);
    logic [31:0] word;
    word = ($urandom << width) | value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, word);
  endtask

  task automatic set_config(input int mx_x, input int mx_y, input int mx_z,
                            input int inv, input int up, input int dev);
    write_reg(REG_MAX_X,  mx_x, POSITION_BITS);
    write_reg(REG_MAX_Y,  mx_y, POSITION_BITS);
    write_reg(REG_MAX_Z,  mx_z, POSITION_BITS);
    write_reg(REG_INVERT, inv,  MASK_BITS);
    write_reg(REG_UPPER,  up,   MASK_BITS);
    write_reg(REG_DEVICE, dev,  MASK_BITS);
    settings_used++;
  endtask

  task automatic run_phase(input int n);
    repeat (n) send_cmd(next_cmd());
    finish_run();
    settle();
  endtask

  // Short hand-picked sequence under reset defaults (x upper nibble,
  // z inverted and on the second port).
  task automatic directed_checks();
    send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd0, 8'h00));       // tick while idle
    send_cmd(mk(FUNC_NONE, 2'd1, 10'd5, 3'd7, 8'hff));       // unused code
    send_cmd(mk(FUNC_MOVE, AXIS_NONE, 10'd10, 3'd0, 8'h5a)); // axis out of range
    send_cmd(mk(FUNC_MOVE, 2'd0, 10'd2, 3'd0, 8'hff));       // two steps forward on x
    repeat (3) send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd7, 8'h00));
    send_cmd(mk(FUNC_HOME, 2'd1, 10'd0, 3'd0, 8'h33));       // command while busy
    while (sb.mode != MODE_IDLE) send_cmd(mk(FUNC_TICK, 2'd3, 10'h3ff, 3'd0, 8'hff));
    send_cmd(mk(FUNC_MOVE, 2'd0, 10'd2, 3'd0, 8'ha5));       // move to current spot
    send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd0, 8'h00));
    send_cmd(mk(FUNC_MOVE, 2'd2, 10'd1, 3'd7, 8'h00));       // inverted z, one step
    while (sb.mode != MODE_IDLE) send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd3, 8'h00));
    send_cmd(mk(FUNC_HOME, 2'd1, 10'h3ff, 3'd0, 8'hc3));     // home y, switch pressed
    send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd2, 8'h00));
    repeat (3) send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd7, 8'h00));
    send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd5, 8'h00));       // released: done
    finish_run();
    settle();
  endtask

  // Longer travel on x, then home with the switch held for a while so
  // back-off climbs a few steps before it releases.
  task automatic long_travel();
    send_cmd(mk(FUNC_MOVE, 2'd0, 10'd64, 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255))));
    finish_run();
    send_cmd(mk(FUNC_HOME, 2'd0, 10'd0, 3'd0, 8'($urandom_range(0, 255))));
    repeat (9) send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd7, 8'h00));
    while (sb.mode != MODE_IDLE) send_cmd(mk(FUNC_TICK, 2'd0, 10'd0, 3'd0, 8'h00));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_if.valid         = 1'b0;
    in_if.func          = '0;
    in_if.axis          = '0;
    in_if.target        = '0;
    in_if.limit_bits    = '0;
    in_if.existing_byte = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    directed_checks();
    run_phase(PHASE_ITEMS);

    // extremes: zero and full-range maxima, all masks clear, then all set
    set_config(0, 1023, 9, 0, 0, 0);
    run_phase(PHASE_ITEMS);
    set_config(5, 12, 0, 7, 7, 7);
    run_phase(PHASE_ITEMS);

    repeat (3) begin
      set_config($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
                 $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
      run_phase(PHASE_ITEMS);
    end

    set_config(1023, 20, 20, 2, 6, 3);
    long_travel();

    repeat (8) @(posedge clk);
    $display("Covered %0d commands (%0d homing) and %0d finished runs over %0d settings,",
             sb.n_cmds, sb.n_homes, sb.n_runs, settings_used);
    $display("with %0d result beats checked and %0d mismatches.", sb.n_beats, sb.errors);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
